// ===== hdl/bpa_pkg.sv =====
// package for the buddy page allocator: payload types, codes, default sizes
package bpa_pkg;

  localparam int POOL_PAGES_DEF = 4096;
  localparam int TOP_ORDER_DEF  = 10;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int ORDER_W = 4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ORDER = 3'd1,
    ST_NO_MEM    = 3'd2,
    ST_DBL_FREE  = 3'd3,
    ST_OUTSIDE   = 3'd4
  } status_t;

  typedef enum logic {
    REG_TOP_BLOCKS = 1'b0,
    REG_BASE_FRAME = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_READ,
    S_A_TAKE,
    S_A_FIXN,
    S_A_SPLIT,
    S_F_READ,
    S_F_CHECK,
    S_F_BUD,
    S_F_BUDCHK,
    S_F_UNLV,
    S_F_UNLN,
    S_F_PUSH,
    S_F_PUSHH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic               operation;
    logic [ORDER_W-1:0] block_order;
    logic [31:0]        address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_address;
  } rsp_t;

endpackage

// ===== hdl/buddy_page_allocator_core.sv =====
// buddy page allocator top level: page memory, free list heads and request sequencer
//
// One request is handled at a time. All per-page state (free flag, order, list links)
// sits in one page memory with a registered read and a single write port, so the
// time a request takes follows the number of memory accesses. An allocate adds a
// step when the taken block has a successor in its list and one per split level
// (up to TOP_ORDER), and a free adds one round of steps per merge level. After
// reset and after every configuration write the page memory is rebuilt by a
// clearing pass over all POOL_PAGES pages, during which no request is taken.
// A finished response sits in an output register, so the next request can enter
// while it waits.
module buddy_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int POOL_PAGES = POOL_PAGES_DEF,
  parameter int TOP_ORDER  = TOP_ORDER_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int PW       = $clog2(POOL_PAGES);
  localparam int IDXW     = $clog2(POOL_PAGES + 1);
  localparam int MAX_TOPS = POOL_PAGES >> TOP_ORDER;
  localparam int EW       = 2 * IDXW + 1 + ORDER_W;
  localparam int FREE_B   = EW - 1;
  localparam int ORD_LO   = 2 * IDXW;
  localparam int NXT_LO   = IDXW;
  localparam logic [IDXW-1:0] NIL      = IDXW'(POOL_PAGES);
  localparam logic [IDXW-1:0] BLK_SIZE = IDXW'(1 << TOP_ORDER);
  localparam logic [IDXW-1:0] BLK_MASK = IDXW'((1 << TOP_ORDER) - 1);
  localparam logic [ORDER_W-1:0] TOP_O = ORDER_W'(TOP_ORDER);

  // configuration and derived pool size
  logic [2:0]  top_blocks;
  logic [19:0] base_frame;
  logic [2:0]  tb_eff;
  logic [2:0]  tops;
  logic [IDXW-1:0] pool_pages;

  always_comb begin
    tb_eff     = (top_blocks == 3'd0) ? 3'd1 : top_blocks;
    tops       = (int'(tb_eff) > MAX_TOPS) ? 3'(MAX_TOPS) : tb_eff;
    pool_pages = IDXW'(IDXW'(tops) << TOP_ORDER);
  end

  // page memory and list heads
  logic [EW-1:0]   mem [POOL_PAGES];
  logic [EW-1:0]   rd_q;
  logic [IDXW-1:0] head [16];

  state_t state, state_next;
  logic [IDXW-1:0]    clr_cnt;
  logic [ORDER_W-1:0] k;
  logic [ORDER_W-1:0] ord;
  logic [PW-1:0]      p;
  logic [PW-1:0]      cur;
  logic [PW-1:0]      bud_r;
  logic [IDXW-1:0]    nbuf;
  logic [IDXW-1:0]    vbuf;
  logic [2:0]         res_status;
  logic               alloc_op;

  // memory port controls
  logic            we_fl, we_nx, we_pv;
  logic [PW-1:0]   wa;
  logic            w_free;
  logic [ORDER_W-1:0] w_ord;
  logic [IDXW-1:0] w_nx, w_pv;
  logic [PW-1:0]   rd_addr;

  // read view of the registered memory word
  logic            q_free;
  logic [ORDER_W-1:0] q_ord;
  logic [IDXW-1:0] q_nx, q_pv;
  assign q_free = rd_q[FREE_B];
  assign q_ord  = rd_q[FREE_B-1:ORD_LO];
  assign q_nx   = rd_q[ORD_LO-1:NXT_LO];
  assign q_pv   = rd_q[IDXW-1:0];

  // request decode
  logic            req_acc, cfg_acc;
  logic            a_found;
  logic [ORDER_W-1:0] a_ord;
  logic [31:0]     pfn, rel;
  logic            f_outside;
  logic [PW-1:0]   bud;
  logic [PW-1:0]   half;
  logic [PW-1:0]   one_pw;
  logic            rsp_load;

  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign req_stall = (state != S_IDLE) || cfg_valid;
  assign req_acc   = req_valid && !req_stall;
  assign rsp_load  = (state == S_RESP) && (!rsp_valid || !rsp_stall);
  assign one_pw    = PW'(1);

  always_comb begin
    a_found = 1'b0;
    a_ord   = '0;
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if (ORDER_W'(i) >= req.block_order && head[i] != NIL) begin
        a_found = 1'b1;
        a_ord   = ORDER_W'(i);
      end
    end
    pfn       = req.address >> PAGE_SHIFT;
    rel       = pfn - 32'(base_frame);
    f_outside = (pfn < 32'(base_frame)) || (rel >= 32'(pool_pages));
    bud       = cur ^ (one_pw << k);
    half      = p | (one_pw << (k - ORDER_W'(1)));
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    we_fl   = 1'b0;
    we_nx   = 1'b0;
    we_pv   = 1'b0;
    wa      = '0;
    w_free  = 1'b0;
    w_ord   = '0;
    w_nx    = NIL;
    w_pv    = NIL;
    rd_addr = cur;
    unique case (state)
      S_CLEAR: begin
        wa    = clr_cnt[PW-1:0];
        we_fl = 1'b1;
        we_nx = 1'b1;
        we_pv = 1'b1;
        if ((clr_cnt & BLK_MASK) == '0 && (clr_cnt >> TOP_ORDER) < IDXW'(tops)) begin
          w_free = 1'b1;
          w_ord  = TOP_O;
          if ((clr_cnt >> TOP_ORDER) + IDXW'(1) < IDXW'(tops)) w_nx = clr_cnt + BLK_SIZE;
          if (clr_cnt != '0) w_pv = clr_cnt - BLK_SIZE;
        end
        if (cfg_acc) state_next = S_CLEAR;
        else if (clr_cnt == IDXW'(POOL_PAGES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_acc) begin
          state_next = S_CLEAR;
        end else if (req_acc) begin
          if (req.operation == OP_ALLOC) begin
            if (req.block_order > TOP_O || !a_found) state_next = S_RESP;
            else state_next = S_A_READ;
          end else begin
            state_next = f_outside ? S_RESP : S_F_READ;
          end
        end
      end
      S_A_READ: begin
        rd_addr    = p;
        state_next = S_A_TAKE;
      end
      S_A_TAKE: begin
        wa    = p;
        we_fl = 1'b1;
        we_nx = 1'b1;
        we_pv = 1'b1;
        w_ord = ord;
        state_next = (q_nx != NIL) ? S_A_FIXN : S_A_SPLIT;
      end
      S_A_FIXN: begin
        wa    = nbuf[PW-1:0];
        we_pv = 1'b1;
        state_next = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (k > ord) begin
          wa     = half;
          we_fl  = 1'b1;
          we_nx  = 1'b1;
          we_pv  = 1'b1;
          w_free = 1'b1;
          w_ord  = k - ORDER_W'(1);
        end else begin
          state_next = S_RESP;
        end
      end
      S_F_READ: begin
        state_next = S_F_CHECK;
      end
      S_F_CHECK: begin
        if (q_free || q_ord > TOP_O) state_next = S_RESP;
        else state_next = S_F_BUD;
      end
      S_F_BUD: begin
        // record the merged order on the current block head
        wa      = cur;
        we_fl   = 1'b1;
        w_ord   = k;
        rd_addr = bud;
        if (k < TOP_O && IDXW'(bud) < pool_pages) state_next = S_F_BUDCHK;
        else state_next = S_F_PUSH;
      end
      S_F_BUDCHK: begin
        if (!q_free || q_ord != k) begin
          state_next = S_F_PUSH;
        end else begin
          wa    = bud_r;
          we_fl = 1'b1;
          we_nx = 1'b1;
          we_pv = 1'b1;
          w_ord = k;
          state_next = S_F_UNLV;
        end
      end
      S_F_UNLV: begin
        wa    = vbuf[PW-1:0];
        w_nx  = nbuf;
        we_nx = (vbuf != NIL);
        state_next = S_F_UNLN;
      end
      S_F_UNLN: begin
        wa    = nbuf[PW-1:0];
        w_pv  = vbuf;
        we_pv = (nbuf != NIL);
        state_next = S_F_BUD;
      end
      S_F_PUSH: begin
        wa     = cur;
        we_fl  = 1'b1;
        we_nx  = 1'b1;
        we_pv  = 1'b1;
        w_free = 1'b1;
        w_ord  = k;
        w_nx   = head[k];
        state_next = S_F_PUSHH;
      end
      S_F_PUSHH: begin
        wa    = nbuf[PW-1:0];
        w_pv  = IDXW'(cur);
        we_pv = (nbuf != NIL);
        state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // page memory
  always_ff @(posedge clk) begin
    if (we_fl) mem[wa][FREE_B:ORD_LO] <= {w_free, w_ord};
    if (we_nx) mem[wa][ORD_LO-1:NXT_LO] <= w_nx;
    if (we_pv) mem[wa][IDXW-1:0] <= w_pv;
    rd_q <= mem[rd_addr];
  end

  // state register and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      top_blocks <= 3'd4;
      base_frame <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        clr_cnt <= '0;
        unique case (reg_idx_t'(cfg_index))
          REG_TOP_BLOCKS: top_blocks <= cfg_data[2:0];
          REG_BASE_FRAME: base_frame <= cfg_data;
          default: ;
        endcase
      end else if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + IDXW'(1);
      end
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // sequencer datapath, list heads and response register
  always_ff @(posedge clk) begin
    if (state == S_CLEAR && clr_cnt == '0) begin
      for (int i = 0; i < 16; i++) begin
        head[i] <= (i == TOP_ORDER && tops != 3'd0) ? '0 : NIL;
      end
    end
    unique case (state)
      S_IDLE: begin
        ord <= req.block_order;
        k   <= a_ord;
        p   <= head[a_ord][PW-1:0];
        cur <= rel[PW-1:0];
        if (req.operation == OP_ALLOC && req.block_order > TOP_O) begin
          res_status <= ST_BAD_ORDER;
        end else if (req.operation == OP_ALLOC && !a_found) begin
          res_status <= ST_NO_MEM;
        end else if (req.operation == OP_FREE && f_outside) begin
          res_status <= ST_OUTSIDE;
        end else begin
          res_status <= ST_OK;
        end
      end
      S_A_TAKE: begin
        head[k] <= q_nx;
        nbuf    <= q_nx;
      end
      S_A_SPLIT: begin
        if (k > ord) begin
          head[k - ORDER_W'(1)] <= IDXW'(half);
          k <= k - ORDER_W'(1);
        end
      end
      S_F_CHECK: begin
        k <= q_ord;
        if (q_free) res_status <= ST_DBL_FREE;
        else if (q_ord > TOP_O) res_status <= ST_BAD_ORDER;
      end
      S_F_BUD: begin
        bud_r <= bud;
      end
      S_F_BUDCHK: begin
        if (q_free && q_ord == k) begin
          nbuf <= q_nx;
          vbuf <= q_pv;
          if (q_pv == NIL) head[k] <= q_nx;
          if (bud_r < cur) cur <= bud_r;
          k <= k + ORDER_W'(1);
        end
      end
      S_F_PUSH: begin
        nbuf    <= head[k];
        head[k] <= IDXW'(cur);
      end
      S_RESP: begin
        if (rsp_load) begin
          rsp.status        <= res_status;
          rsp.block_address <= (res_status == ST_OK && alloc_op)
                               ? (32'(base_frame) + 32'(p)) << PAGE_SHIFT : '0;
        end
      end
      default: ;
    endcase
  end

  // remember which operation is in flight
  always_ff @(posedge clk) begin
    if (req_acc) alloc_op <= (req.operation == OP_ALLOC);
  end

  // no request enters while the page memory is being rebuilt
  assert property (@(posedge clk) disable iff (rst) state == S_CLEAR |-> req_stall)
    else $error("request taken during clearing pass");

  // one request at a time: an accepted request stalls the next cycle
  assert property (@(posedge clk) disable iff (rst) req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

  // errors never return an address
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.block_address == '0)
    else $error("error response carries an address");

endmodule

// ===== dv/bpa_checker.sv =====
// checker for the buddy page allocator: watches all channels, predicts and compares responses
module bpa_checker
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES = POOL_PAGES_DEF;
  localparam int TOPO  = TOP_ORDER_DEF;
  localparam int SHIFT = PAGE_SHIFT_DEF;
  localparam int NIL   = PAGES;

  // shadow allocator state
  bit          pg_free [PAGES];
  logic [3:0]  pg_ord  [PAGES];
  int          pg_next [PAGES];
  int          pg_prev [PAGES];
  int          fl_head [TOPO+1];
  int          span_pages;
  logic [2:0]  tops_reg;
  logic [19:0] base_reg;

  rsp_t exp_rsps[$];

  assign pending = exp_rsps.size();

  function automatic void unlink_entry(int p, int k);
    int n, v;
    n = pg_next[p];
    v = pg_prev[p];
    if (v < NIL) pg_next[v] = n;
    else fl_head[k] = n;
    if (n < NIL) pg_prev[n] = v;
    pg_next[p] = NIL;
    pg_prev[p] = NIL;
  endfunction

  function automatic void list_push(int p, int k);
    int h;
    h = fl_head[k];
    pg_prev[p] = NIL;
    pg_next[p] = h;
    if (h < NIL) pg_prev[h] = p;
    fl_head[k] = p;
  endfunction

  function automatic void pool_rebuild();
    int tops, sz;
    sz = 1 << TOPO;
    tops = (tops_reg == 0) ? 1 : int'(tops_reg);
    if (tops > (PAGES >> TOPO)) tops = PAGES >> TOPO;
    span_pages = tops << TOPO;
    for (int i = 0; i < PAGES; i++) begin
      pg_free[i] = 0;
      pg_ord[i]  = 0;
      pg_next[i] = NIL;
      pg_prev[i] = NIL;
    end
    for (int i = 0; i <= TOPO; i++) fl_head[i] = NIL;
    for (int b = 0; b < tops; b++) begin
      pg_free[b*sz] = 1;
      pg_ord[b*sz]  = TOPO;
      pg_prev[b*sz] = (b == 0) ? NIL : (b-1)*sz;
      pg_next[b*sz] = (b+1 < tops) ? (b+1)*sz : NIL;
    end
    if (tops > 0) fl_head[TOPO] = 0;
  endfunction

  // allocate or free one block, return the expected response
  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    int   ord, p, k, cur, bud;
    logic [31:0] pfn;
    o.status = ST_OK;
    o.block_address = '0;
    if (op_t'(r.operation) == OP_ALLOC) begin
      ord = r.block_order;
      if (ord > TOPO) begin
        o.status = ST_BAD_ORDER;
        return o;
      end
      k = ord;
      while (k <= TOPO && fl_head[k] >= NIL) k++;
      if (k > TOPO) begin
        o.status = ST_NO_MEM;
        return o;
      end
      p = fl_head[k];
      unlink_entry(p, k);
      pg_free[p] = 0;
      // split down, upper halves go back to their lists
      for (; k > ord; k--) begin
        pg_free[p + (1 << (k-1))] = 1;
        pg_ord[p + (1 << (k-1))]  = 4'(k-1);
        list_push(p + (1 << (k-1)), k-1);
      end
      pg_ord[p] = 4'(ord);
      o.block_address = (32'(base_reg) + 32'(p)) << SHIFT;
    end else begin
      pfn = r.address >> SHIFT;
      if (pfn < 32'(base_reg) || pfn - 32'(base_reg) >= 32'(span_pages)) begin
        o.status = ST_OUTSIDE;
        return o;
      end
      cur = int'(pfn - 32'(base_reg));
      if (pg_free[cur]) begin
        o.status = ST_DBL_FREE;
        return o;
      end
      k = pg_ord[cur];
      if (k > TOPO) begin
        o.status = ST_BAD_ORDER;
        return o;
      end
      // merge with free buddies of equal order
      while (k < TOPO) begin
        bud = cur ^ (1 << k);
        if (bud >= span_pages || !pg_free[bud] || pg_ord[bud] != k) break;
        unlink_entry(bud, k);
        pg_free[bud] = 0;
        if (bud < cur) cur = bud;
        k++;
        pg_ord[cur] = 4'(k);
      end
      pg_free[cur] = 1;
      pg_ord[cur]  = 4'(k);
      list_push(cur, k);
    end
    return o;
  endfunction

  // track transactions on every channel
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      tops_reg = 3'd4;
      base_reg = '0;
      pool_rebuild();
      exp_rsps.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (reg_idx_t'(cfg_index) == REG_TOP_BLOCKS) tops_reg = cfg_data[2:0];
        else base_reg = cfg_data;
        pool_rebuild();
      end
      if (req_valid && !req_stall) exp_rsps.push_back(predict_rsp(req));
      if (rsp_valid && !rsp_stall) begin
        if (exp_rsps.size() == 0) begin
          $error("unexpected response status=%0d block_address=%h",
                 rsp.status, rsp.block_address);
          fail_count++;
        end else begin
          e = exp_rsps.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, rsp.status);
            fail_count++;
          end
          if (rsp.block_address !== e.block_address) begin
            $error("block_address: expected %h actual %h",
                   e.block_address, rsp.block_address);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb.sv =====
// testbench top for the buddy page allocator: clock, reset, stimulus and verdict
module tb;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 0;
  rsp_t        rsp;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [19:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  bit          calm = 0;
  int          sent = 0;
  op_t         issued_ops[$];
  logic [31:0] held_blocks[$];

  buddy_page_allocator_core dut (.*);

  bpa_checker chk (.*);

  always #2 clk = ~clk;

  // random backpressure on the response side
  always @(posedge clk) begin
    rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);
  end

  // remember granted blocks so that most frees hit real allocations
  always @(posedge clk) begin
    op_t o;
    if (!rst && rsp_valid && !rsp_stall && issued_ops.size() > 0) begin
      o = issued_ops.pop_front();
      if (o == OP_ALLOC && status_t'(rsp.status) == ST_OK)
        held_blocks.push_back(rsp.block_address);
    end
  end

  task automatic send_req(op_t op, int ord, logic [31:0] addr);
    if (!calm && $urandom_range(0, 99) < 34) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req.operation <= op;
    req.block_order <= 4'(ord);
    req.address <= addr;
    do @(posedge clk); while (req_stall);
    issued_ops.push_back(op);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    held_blocks.delete();
  endtask

  task automatic random_items(int n, logic [19:0] base);
    int r, j;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && held_blocks.size() == 0)) begin
        send_req(OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 4),
                 $urandom());
      end else if (r < 85) begin
        j = $urandom_range(0, held_blocks.size() - 1);
        a = held_blocks[j] | 32'($urandom_range(0, 4095));
        held_blocks.delete(j);
        send_req(OP_FREE, $urandom_range(0, 15), a);
      end else if (r < 93) begin
        a = (32'(base) + 32'($urandom_range(0, 4095))) << PAGE_SHIFT_DEF;
        send_req(OP_FREE, $urandom_range(0, 15), a | 32'($urandom_range(0, 4095)));
      end else begin
        send_req(OP_FREE, $urandom_range(0, 15), $urandom());
      end
    end
  endtask

  initial begin
    logic [19:0] rb;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: deep split, invalid orders, errors, odd frees, exhaustion
    send_req(OP_ALLOC, 0, 32'hFFFF_FFFF);
    send_req(OP_ALLOC, 10, 32'h0);
    send_req(OP_ALLOC, 11, 32'h0);
    send_req(OP_ALLOC, 15, 32'h0);
    send_req(OP_ALLOC, 0, 32'h0);
    send_req(OP_FREE, 0, 32'h0000_0FFF);
    send_req(OP_FREE, 15, 32'h0000_0000);
    send_req(OP_FREE, 0, 32'hFFFF_FFFF);
    send_req(OP_FREE, 0, 32'h0100_0000);
    send_req(OP_FREE, 0, 32'h0000_3ABC);
    send_req(OP_FREE, 0, 32'h0000_1000);
    send_req(OP_ALLOC, 10, 32'h0);
    send_req(OP_ALLOC, 10, 32'h0);
    send_req(OP_ALLOC, 10, 32'h0);
    send_req(OP_ALLOC, 10, 32'h0);
    send_req(OP_ALLOC, 3, 32'h0);
    send_req(OP_FREE, 0, 32'h0040_0000);
    send_req(OP_FREE, 0, 32'h0040_0000);
    send_req(OP_ALLOC, 10, 32'h0);
    drain();

    // phases over pool sizes and base frames, extremes included
    rb = 20'($urandom());
    write_reg(REG_TOP_BLOCKS, {17'($urandom()), 3'd4});
    random_items(150, 20'd0);
    drain();
    write_reg(REG_BASE_FRAME, 20'hFFFFF);
    write_reg(REG_TOP_BLOCKS, {17'h1FFFF, 3'd1});
    random_items(150, 20'hFFFFF);
    drain();
    write_reg(REG_BASE_FRAME, 20'h00001);
    write_reg(REG_TOP_BLOCKS, {17'h0, 3'd0});
    calm = 1;
    random_items(150, 20'h00001);
    drain();
    calm = 0;
    write_reg(REG_BASE_FRAME, 20'hABCDE);
    write_reg(REG_TOP_BLOCKS, {17'($urandom()), 3'd7});
    random_items(150, 20'hABCDE);
    drain();
    write_reg(REG_BASE_FRAME, rb);
    write_reg(REG_TOP_BLOCKS, {17'($urandom()), 3'd2});
    random_items(150, rb);
    drain();
    write_reg(REG_BASE_FRAME, 20'h0);
    write_reg(REG_TOP_BLOCKS, {17'($urandom()), 3'd3});
    random_items(150, 20'h0);
    drain();

    $display("run covered %0d requests over seven pool setups (1 to 4 top blocks,", sent);
    $display("base frames from 0 to the top), with splits, merges and error cases");
    if (fail_count == 0) begin
      $display("buddy_page_allocator_core verification clean");
    end else begin
      $display("buddy_page_allocator_core verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("buddy_page_allocator_core verification failed");
    $finish;
  end
endmodule

// ===== buddy_page_allocator_core.f =====
hdl/bpa_pkg.sv
hdl/buddy_page_allocator_core.sv
dv/bpa_checker.sv
dv/tb.sv
